// ===== hw/rtl/bdtw_pkg.sv =====
// ----------------------------------------------------------------------------
// bdtw_pkg
// Shared widths, constants and types for the banded DTW distance block.
// ----------------------------------------------------------------------------
package bdtw_pkg;

   // Sequence storage
   localparam int MAX_LEN    = 1024;
   localparam int ADDR_W     = $clog2(MAX_LEN);
   localparam int CNT_W      = ADDR_W + 1;

   // Band radius
   localparam int MAX_RADIUS = 64;
   localparam int RAD_W      = 7;
   localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(8);

   // Coordinates and costs
   localparam int COORD_W    = 16;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int PC_W       = SQ_W + 1;
   localparam int COST_W     = 48;
   localparam logic [COST_W-1:0] COST_INF = '1;

   // One stored point pair member, x in the low half
   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   // One element issued into the cell pipeline
   typedef struct packed {
      logic              valid;
      logic              pre;      // diagonal pre-read, not a cell
      logic              first;    // first cell of the row, no left neighbor
      logic              origin;   // cell (0,0)
      logic              up_ok;
      logic              diag_ok;
      logic [ADDR_W-1:0] col;
   } issue_type;

   // Pipeline status back to the sequencer
   typedef struct packed {
      logic              busy;
      logic [COST_W-1:0] best;
      logic [COST_W-1:0] last_cost;
   } pipe_status_type;

endpackage

// ===== hw/rtl/banded_dtw_distance.sv =====
// ----------------------------------------------------------------------------
// banded_dtw_distance
// Banded dynamic time warping distance with early abandon over 2-D points.
// ----------------------------------------------------------------------------
// A request with tlast starts the run. Each matrix row does a query/diagonal
// pre-read, one cell per cycle across the band (2r+1 columns, clipped at the
// ends), then a drain until the cell pipeline is idle. rsp_tvalid and
// req_tready rise together once the result state follows the final row check,
// later while the previous response is still pending.
// Reset clears control and sets band_radius to 8; stores are not cleared.
module banded_dtw_distance (
   input  logic          clock,
   input  logic          reset,
   // query_x[15:0], query_y[31:16], data_x[47:32], data_y[63:48],
   // abandon_threshold[111:64]
   input  logic [111:0]  req_tdata,
   input  logic          req_tlast,     // last_point
   input  logic          req_tvalid,
   output logic          req_tready,
   // warp_distance[47:0]
   output logic [47:0]   rsp_tdata,
   output logic [0:0]    rsp_tuser,     // abandoned
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          csr_wr_en,
   input  logic [6:0]    csr_wr_data    // band_radius
);

   logic [bdtw_pkg::RAD_W-1:0]  radius_ff;
   logic [bdtw_pkg::RAD_W-1:0]  radius_eff;
   bdtw_pkg::point_type         wr_query;
   bdtw_pkg::point_type         wr_cand;
   logic [bdtw_pkg::COST_W-1:0] req_threshold;
   logic                        store_wr_en;
   logic [bdtw_pkg::ADDR_W-1:0] store_wr_addr;
   logic                        q_rd_en;
   logic [bdtw_pkg::ADDR_W-1:0] q_rd_addr;
   bdtw_pkg::point_type         q_rd_data;
   bdtw_pkg::point_type         c_rd_data;
   bdtw_pkg::issue_type         issue;
   bdtw_pkg::pipe_status_type   status;
   logic [bdtw_pkg::COST_W-1:0] rsp_distance;
   logic                        rsp_abandoned;

   // Band radius register, clamped to MAX_RADIUS (64)
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= bdtw_pkg::RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   assign radius_eff = (radius_ff > bdtw_pkg::RAD_W'(bdtw_pkg::MAX_RADIUS))
                       ? bdtw_pkg::RAD_W'(bdtw_pkg::MAX_RADIUS) : radius_ff;

   // Request unpacking
   assign wr_query.x    = req_tdata[15:0];
   assign wr_query.y    = req_tdata[31:16];
   assign wr_cand.x     = req_tdata[47:32];
   assign wr_cand.y     = req_tdata[63:48];
   assign req_threshold = req_tdata[111:64];

   bdtw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .radius        (radius_eff),
      .req_tvalid    (req_tvalid),
      .req_tlast     (req_tlast),
      .req_threshold (req_threshold),
      .req_tready    (req_tready),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .q_rd_en       (q_rd_en),
      .q_rd_addr     (q_rd_addr),
      .issue         (issue),
      .status        (status),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_distance  (rsp_distance),
      .rsp_abandoned (rsp_abandoned)
   );

   bdtw_point_mem u_point_mem (
      .clock     (clock),
      .wr_en     (store_wr_en),
      .wr_addr   (store_wr_addr),
      .wr_query  (wr_query),
      .wr_cand   (wr_cand),
      .q_rd_en   (q_rd_en),
      .q_rd_addr (q_rd_addr),
      .c_rd_en   (issue.valid),
      .c_rd_addr (issue.col),
      .q_rd_data (q_rd_data),
      .c_rd_data (c_rd_data)
   );

   bdtw_cell_pipe u_cell_pipe (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .query_pt (q_rd_data),
      .cand_pt  (c_rd_data),
      .status   (status)
   );

   // Response packing
   assign rsp_tdata    = rsp_distance;
   assign rsp_tuser[0] = rsp_abandoned;

endmodule

// ===== hw/rtl/bdtw_point_mem.sv =====
// ----------------------------------------------------------------------------
// bdtw_point_mem
// Query and candidate point stores, one write port, registered read data.
// ----------------------------------------------------------------------------
module bdtw_point_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [bdtw_pkg::ADDR_W-1:0]  wr_addr,
   input  bdtw_pkg::point_type          wr_query,
   input  bdtw_pkg::point_type          wr_cand,
   input  logic                         q_rd_en,
   input  logic [bdtw_pkg::ADDR_W-1:0]  q_rd_addr,
   input  logic                         c_rd_en,
   input  logic [bdtw_pkg::ADDR_W-1:0]  c_rd_addr,
   output bdtw_pkg::point_type          q_rd_data,
   output bdtw_pkg::point_type          c_rd_data
);

   bdtw_pkg::point_type query_mem [bdtw_pkg::MAX_LEN];
   bdtw_pkg::point_type cand_mem  [bdtw_pkg::MAX_LEN];
   bdtw_pkg::point_type q_rd_ff;
   bdtw_pkg::point_type c_rd_ff;

   // Load port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         query_mem[wr_addr] <= wr_query;
         cand_mem[wr_addr]  <= wr_cand;
      end
   end

   // Query read, held for a whole row
   always_ff @(posedge clock) begin
      if (q_rd_en) begin
         q_rd_ff <= query_mem[q_rd_addr];
      end
   end

   // Candidate read, one per issued element
   always_ff @(posedge clock) begin
      if (c_rd_en) begin
         c_rd_ff <= cand_mem[c_rd_addr];
      end
   end

   assign q_rd_data = q_rd_ff;
   assign c_rd_data = c_rd_ff;

endmodule

// ===== hw/rtl/bdtw_cell_pipe.sv =====
// ----------------------------------------------------------------------------
// bdtw_cell_pipe
// Cell cost pipeline around the column-indexed row memory: read up value,
// square distances, neighbor minimum, saturating add, write back.
// ----------------------------------------------------------------------------
module bdtw_cell_pipe (
   input  logic                         clock,
   input  logic                         reset,
   input  bdtw_pkg::issue_type          issue,
   input  bdtw_pkg::point_type          query_pt,
   input  bdtw_pkg::point_type          cand_pt,
   output bdtw_pkg::pipe_status_type    status
);

   // Row memory: entry j holds the latest finished cost of column j
   logic [bdtw_pkg::COST_W-1:0] row_mem [bdtw_pkg::MAX_LEN];
   logic [bdtw_pkg::COST_W-1:0] up_rd_ff;

   // Stage B: memory data present
   logic                        vb_ff;
   bdtw_pkg::issue_type         b_ff;
   logic [bdtw_pkg::COST_W-1:0] prev_up_ff;

   // Stage C
   logic                        vc_ff;
   logic [bdtw_pkg::SQ_W-1:0]   sqx_ff;
   logic [bdtw_pkg::SQ_W-1:0]   sqy_ff;
   logic [bdtw_pkg::COST_W-1:0] md1_ff;
   logic                        c_first_ff;
   logic                        c_origin_ff;
   logic [bdtw_pkg::ADDR_W-1:0] c_col_ff;

   // Stage D
   logic                        vd_ff;
   logic [bdtw_pkg::PC_W-1:0]   pc_ff;
   logic [bdtw_pkg::COST_W-1:0] md2_ff;
   logic                        d_first_ff;
   logic                        d_origin_ff;
   logic [bdtw_pkg::ADDR_W-1:0] d_col_ff;

   // Stage E: finished cell
   logic                        ve_ff;
   logic [bdtw_pkg::COST_W-1:0] cost_ff;
   logic [bdtw_pkg::ADDR_W-1:0] e_col_ff;
   logic [bdtw_pkg::COST_W-1:0] best_ff;
   logic [bdtw_pkg::COST_W-1:0] last_cost_ff;

   logic signed [bdtw_pkg::COORD_W:0]     dx;
   logic signed [bdtw_pkg::COORD_W:0]     dy;
   logic signed [2*bdtw_pkg::COORD_W+1:0] px;
   logic signed [2*bdtw_pkg::COORD_W+1:0] py;
   logic [bdtw_pkg::SQ_W-1:0]   sqx_in;
   logic [bdtw_pkg::SQ_W-1:0]   sqy_in;
   logic [bdtw_pkg::COST_W-1:0] up_val;
   logic [bdtw_pkg::COST_W-1:0] diag_val;
   logic [bdtw_pkg::COST_W-1:0] md1_in;
   logic [bdtw_pkg::PC_W-1:0]   pc_in;
   logic [bdtw_pkg::COST_W-1:0] nb;
   logic [bdtw_pkg::COST_W:0]   sum;
   logic [bdtw_pkg::COST_W-1:0] cost_in;

   // Row memory: read at issue, write back at the end of the pipe
   always_ff @(posedge clock) begin
      if (issue.valid) begin
         up_rd_ff <= row_mem[issue.col];
      end
      if (ve_ff) begin
         row_mem[e_col_ff] <= cost_ff;
      end
   end

   // Stage B: squared coordinate differences, up/diag minimum
   always_comb begin
      dx       = {query_pt.x[bdtw_pkg::COORD_W-1], query_pt.x}
               - {cand_pt.x[bdtw_pkg::COORD_W-1], cand_pt.x};
      dy       = {query_pt.y[bdtw_pkg::COORD_W-1], query_pt.y}
               - {cand_pt.y[bdtw_pkg::COORD_W-1], cand_pt.y};
      px       = dx * dx;
      py       = dy * dy;
      sqx_in   = px[bdtw_pkg::SQ_W-1:0];
      sqy_in   = py[bdtw_pkg::SQ_W-1:0];
      up_val   = b_ff.up_ok   ? up_rd_ff   : bdtw_pkg::COST_INF;
      diag_val = b_ff.diag_ok ? prev_up_ff : bdtw_pkg::COST_INF;
      md1_in   = (up_val < diag_val) ? up_val : diag_val;
   end

   // Stage C: point cost
   assign pc_in = bdtw_pkg::PC_W'(sqx_ff) + bdtw_pkg::PC_W'(sqy_ff);

   // Stage D: left neighbor is the previously finished cell, held in cost_ff
   always_comb begin
      nb = md2_ff;
      if (!d_first_ff && (cost_ff < md2_ff)) begin
         nb = cost_ff;
      end
      sum = (bdtw_pkg::COST_W+1)'(pc_ff) + (bdtw_pkg::COST_W+1)'(nb);
      if (d_origin_ff) begin
         cost_in = bdtw_pkg::COST_W'(pc_ff);
      end else if (sum[bdtw_pkg::COST_W]) begin
         cost_in = bdtw_pkg::COST_INF;
      end else begin
         cost_in = sum[bdtw_pkg::COST_W-1:0];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         vb_ff <= issue.valid;
         vc_ff <= vb_ff && !b_ff.pre;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      b_ff <= issue;
      if (vb_ff) begin
         prev_up_ff <= up_rd_ff;
      end
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      md1_ff      <= md1_in;
      c_first_ff  <= b_ff.first;
      c_origin_ff <= b_ff.origin;
      c_col_ff    <= b_ff.col;
      pc_ff       <= pc_in;
      md2_ff      <= md1_ff;
      d_first_ff  <= c_first_ff;
      d_origin_ff <= c_origin_ff;
      d_col_ff    <= c_col_ff;
      if (vd_ff) begin
         cost_ff <= cost_in;
      end
      e_col_ff    <= d_col_ff;
   end

   // Row minimum and latest cell cost
   always_ff @(posedge clock) begin
      if (issue.valid && issue.pre) begin
         best_ff <= bdtw_pkg::COST_INF;
      end else if (ve_ff && (cost_ff < best_ff)) begin
         best_ff <= cost_ff;
      end
      if (ve_ff) begin
         last_cost_ff <= cost_ff;
      end
   end

   assign status.busy      = vb_ff | vc_ff | vd_ff | ve_ff;
   assign status.best      = best_ff;
   assign status.last_cost = last_cost_ff;

endmodule

// ===== hw/rtl/bdtw_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdtw_ctrl
// Sequencer: loads point pairs, walks the band row by row, checks the abandon
// bound after rows whose band misses the last column, holds the result register.
// ----------------------------------------------------------------------------
module bdtw_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bdtw_pkg::RAD_W-1:0]    radius,
   input  logic                          req_tvalid,
   input  logic                          req_tlast,
   input  logic [bdtw_pkg::COST_W-1:0]   req_threshold,
   output logic                          req_tready,
   output logic                          store_wr_en,
   output logic [bdtw_pkg::ADDR_W-1:0]   store_wr_addr,
   output logic                          q_rd_en,
   output logic [bdtw_pkg::ADDR_W-1:0]   q_rd_addr,
   output bdtw_pkg::issue_type           issue,
   input  bdtw_pkg::pipe_status_type     status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bdtw_pkg::COST_W-1:0]   rsp_distance,
   output logic                          rsp_abandoned
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PRE,
      ST_CELLS,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   state_type                     state_ff;
   logic [bdtw_pkg::CNT_W-1:0]    count_ff;
   logic [bdtw_pkg::CNT_W-1:0]    m_ff;
   logic [bdtw_pkg::COST_W-1:0]   thr_ff;
   logic [bdtw_pkg::ADDR_W-1:0]   row_ff;
   logic [bdtw_pkg::ADDR_W-1:0]   col_ff;
   logic [bdtw_pkg::ADDR_W-1:0]   jhi_ff;
   logic                          first_ff;
   logic [bdtw_pkg::COST_W-1:0]   res_dist_ff;
   logic                          res_abn_ff;
   logic                          rsp_valid_ff;
   logic [bdtw_pkg::COST_W-1:0]   rsp_dist_ff;
   logic                          rsp_abn_ff;

   logic                          accept;
   logic [bdtw_pkg::CNT_W-1:0]    count_inc;
   logic [bdtw_pkg::CNT_W-1:0]    row_plus_r;
   logic [bdtw_pkg::CNT_W-1:0]    last_idx;
   logic [bdtw_pkg::ADDR_W-1:0]   jlo;
   logic [bdtw_pkg::ADDR_W-1:0]   jhi;
   logic                          more_rows;
   logic                          abandon;

   // Load handshake and store slot; the last slot is reused once full
   always_comb begin
      req_tready  = (state_ff == ST_LOAD);
      accept      = req_tvalid && req_tready;
      store_wr_en = accept;
      if (count_ff >= bdtw_pkg::CNT_W'(bdtw_pkg::MAX_LEN)) begin
         store_wr_addr = bdtw_pkg::ADDR_W'(bdtw_pkg::MAX_LEN - 1);
         count_inc     = count_ff;
      end else begin
         store_wr_addr = count_ff[bdtw_pkg::ADDR_W-1:0];
         count_inc     = count_ff + 1'b1;
      end
   end

   // Band limits of the current row
   always_comb begin
      row_plus_r = bdtw_pkg::CNT_W'(row_ff) + bdtw_pkg::CNT_W'(radius);
      last_idx   = m_ff - 1'b1;
      if (bdtw_pkg::CNT_W'(row_ff) > bdtw_pkg::CNT_W'(radius)) begin
         jlo = row_ff - bdtw_pkg::ADDR_W'(radius);
      end else begin
         jlo = '0;
      end
      if (row_plus_r < last_idx) begin
         jhi = row_plus_r[bdtw_pkg::ADDR_W-1:0];
      end else begin
         jhi = last_idx[bdtw_pkg::ADDR_W-1:0];
      end
      more_rows = (row_plus_r < last_idx);
      abandon   = more_rows && (status.best >= thr_ff);
   end

   // Issue: one diagonal pre-read, then one cell per cycle
   always_comb begin
      issue.valid   = (state_ff == ST_PRE) || (state_ff == ST_CELLS);
      issue.pre     = (state_ff == ST_PRE);
      issue.col     = (state_ff == ST_PRE) ? (jlo - 1'b1) : col_ff;
      issue.first   = first_ff;
      issue.origin  = (row_ff == '0) && (col_ff == '0);
      issue.up_ok   = (row_ff != '0) && (bdtw_pkg::CNT_W'(col_ff) < row_plus_r);
      issue.diag_ok = (row_ff != '0) && (col_ff != '0);
      q_rd_en       = (state_ff == ST_PRE);
      q_rd_addr     = row_ff;
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Response taken; in ST_RESULT the reload below handles it
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (req_tlast) begin
                     m_ff     <= count_inc;
                     count_ff <= '0;
                     thr_ff   <= req_threshold;
                     row_ff   <= '0;
                     state_ff <= ST_PRE;
                  end else begin
                     count_ff <= count_inc;
                  end
               end
            end
            ST_PRE: begin
               col_ff   <= jlo;
               jhi_ff   <= jhi;
               first_ff <= 1'b1;
               state_ff <= ST_CELLS;
            end
            ST_CELLS: begin
               first_ff <= 1'b0;
               col_ff   <= col_ff + 1'b1;
               if (col_ff == jhi_ff) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!status.busy) begin
                  if (abandon) begin
                     res_dist_ff <= status.best;
                     res_abn_ff  <= 1'b1;
                     state_ff    <= ST_RESULT;
                  end else if (bdtw_pkg::CNT_W'(row_ff) == last_idx) begin
                     res_dist_ff <= status.last_cost;
                     res_abn_ff  <= 1'b0;
                     state_ff    <= ST_RESULT;
                  end else begin
                     row_ff   <= row_ff + 1'b1;
                     state_ff <= ST_PRE;
                  end
               end
            end
            ST_RESULT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_dist_ff  <= res_dist_ff;
                  rsp_abn_ff   <= res_abn_ff;
                  state_ff     <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_abandoned = rsp_abn_ff;

endmodule
